[src/yma_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the yuv matrix to argb pixel pipeline
// no dependencies

package yma_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 16;
	localparam int REG_W    = 48;
	localparam int NUM_CH   = 3;
	localparam int PROD_W   = SAMPLE_W + COEF_W;
	localparam int SUM_W    = PROD_W + 2;
	localparam int BYTE_W   = 8;
	localparam int IDX_W    = 3;

	localparam logic [BYTE_W-1:0] ALPHA_MAX = 8'd255;

	localparam logic [IDX_W-1:0] REG_ROW0  = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROW1  = 3'd1;
	localparam logic [IDX_W-1:0] REG_ROW2  = 3'd2;
	localparam logic [IDX_W-1:0] REG_OFFS  = 3'd3;
	localparam logic [IDX_W-1:0] REG_AMODE = 3'd4;

	// stage advance enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} adv_t;

	// raw side data traveling with a word
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] alpha;
		logic                       last;
	} side_t;

	// side data after alpha resolve
	typedef struct packed {
		logic [BYTE_W-1:0] alpha;
		logic              last;
	} pix_side_t;

	typedef logic [NUM_CH-1:0][PROD_W-1:0] prod_row_t;

endpackage

[src/yma_mul_stage.sv]
`timescale 1ns / 1ps
// stage 1: nine signed coefficient by sample products
// depends on yma_pkg

module yma_mul_stage (
	input  logic                                       clk,
	input  yma_pkg::adv_t                              adv,
	input  logic signed [yma_pkg::SAMPLE_W-1:0]        sample_y,
	input  logic signed [yma_pkg::SAMPLE_W-1:0]        sample_u,
	input  logic signed [yma_pkg::SAMPLE_W-1:0]        sample_v,
	input  yma_pkg::side_t                             side_in,
	input  logic [yma_pkg::NUM_CH-1:0][yma_pkg::REG_W-1:0] rows,
	output yma_pkg::prod_row_t [yma_pkg::NUM_CH-1:0]   prod_s1,
	output yma_pkg::side_t                             side_s1
);

	logic signed [yma_pkg::SAMPLE_W-1:0] samp [yma_pkg::NUM_CH];

	assign samp[0] = sample_y;
	assign samp[1] = sample_u;
	assign samp[2] = sample_v;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			for (int c = 0; c < yma_pkg::NUM_CH; c++) begin
				for (int k = 0; k < yma_pkg::NUM_CH; k++) begin
					prod_s1[c][k] <= $signed(rows[c][yma_pkg::COEF_W*k +: yma_pkg::COEF_W])
						* samp[k];
				end
			end
			side_s1 <= side_in;
		end
	end

endmodule

[src/yma_acc_stage.sv]
`timescale 1ns / 1ps
// stages 2 and 3: product sum with rounding, then shift, offset and alpha resolve
// depends on yma_pkg

module yma_acc_stage #(
	parameter int FRACTION_BITS = 12,
	parameter int CH_W          = yma_pkg::SUM_W - FRACTION_BITS + 1
) (
	input  logic                                     clk,
	input  yma_pkg::adv_t                            adv,
	input  yma_pkg::prod_row_t [yma_pkg::NUM_CH-1:0] prod_s1,
	input  yma_pkg::side_t                           side_s1,
	input  logic [yma_pkg::REG_W-1:0]                offsets,
	input  logic                                     alpha_mode,
	output logic [yma_pkg::NUM_CH-1:0][CH_W-1:0]     chan_s3,
	output yma_pkg::pix_side_t                       side_s3
);

	localparam int SUM_W = yma_pkg::SUM_W;
	localparam int SHR_W = SUM_W - FRACTION_BITS;
	localparam logic [SUM_W-1:0] RND = SUM_W'(1) << (FRACTION_BITS - 1);

	logic [yma_pkg::NUM_CH-1:0][SUM_W-1:0] sum_d;
	logic [yma_pkg::NUM_CH-1:0][SUM_W-1:0] sum_s2;
	logic [yma_pkg::NUM_CH-1:0][CH_W-1:0]  chan_d;
	logic [yma_pkg::NUM_CH-1:0][SUM_W-1:0] shr;
	yma_pkg::side_t                        side_s2;
	logic [yma_pkg::BYTE_W-1:0]            alpha_d;

	always_comb begin
		for (int c = 0; c < yma_pkg::NUM_CH; c++) begin
			sum_d[c] = SUM_W'($signed(prod_s1[c][0])) + SUM_W'($signed(prod_s1[c][1]))
				+ SUM_W'($signed(prod_s1[c][2])) + RND;
		end
	end

	always_comb begin
		for (int c = 0; c < yma_pkg::NUM_CH; c++) begin
			shr[c]    = $signed(sum_s2[c]) >>> FRACTION_BITS;
			chan_d[c] = CH_W'($signed(shr[c][SHR_W-1:0]))
				+ CH_W'($signed(offsets[yma_pkg::COEF_W*c +: yma_pkg::COEF_W]));
		end
	end

	always_comb begin
		if (!alpha_mode) begin
			alpha_d = yma_pkg::ALPHA_MAX;
		end else if (side_s2.alpha < 0) begin
			alpha_d = '0;
		end else if (side_s2.alpha > $signed({8'd0, yma_pkg::ALPHA_MAX})) begin
			alpha_d = yma_pkg::ALPHA_MAX;
		end else begin
			alpha_d = side_s2.alpha[yma_pkg::BYTE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			sum_s2  <= sum_d;
			side_s2 <= side_s1;
		end
		if (adv.s3) begin
			chan_s3       <= chan_d;
			side_s3.alpha <= alpha_d;
			side_s3.last  <= side_s2.last;
		end
	end

endmodule

[src/yma_clamp_stage.sv]
`timescale 1ns / 1ps
// stage 4: clamp each channel to 0..alpha and drive the output registers
// depends on yma_pkg

module yma_clamp_stage #(
	parameter int CH_W = 23
) (
	input  logic                                 clk,
	input  yma_pkg::adv_t                        adv,
	input  logic [yma_pkg::NUM_CH-1:0][CH_W-1:0] chan_s3,
	input  yma_pkg::pix_side_t                   side_s3,
	output logic [yma_pkg::NUM_CH-1:0][yma_pkg::BYTE_W-1:0] chan_s4,
	output yma_pkg::pix_side_t                   side_s4
);

	logic [yma_pkg::NUM_CH-1:0][yma_pkg::BYTE_W-1:0] clamp_d;
	logic signed [CH_W-1:0]                          top;

	assign top = $signed(CH_W'(side_s3.alpha));

	// alpha zero clamps every channel to zero
	always_comb begin
		for (int c = 0; c < yma_pkg::NUM_CH; c++) begin
			if ($signed(chan_s3[c]) < 0) begin
				clamp_d[c] = '0;
			end else if ($signed(chan_s3[c]) > top) begin
				clamp_d[c] = side_s3.alpha;
			end else begin
				clamp_d[c] = chan_s3[c][yma_pkg::BYTE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			chan_s4 <= clamp_d;
			side_s4 <= side_s3;
		end
	end

endmodule

[src/yuv_matrix_to_argb_pixel_core.sv]
`timescale 1ns / 1ps
// top level: config registers, pipeline valid and stall control
// depends on yma_pkg, yma_mul_stage, yma_acc_stage, yma_clamp_stage

// Converts one signed YUV pixel plus alpha into an 8-bit ARGB pixel per clock
// while in_stall is low. Four register stages, in order: products, sum with
// rounding, shift with offset and alpha resolve, clamp. One word is accepted
// every cycle while in_stall is low; in_stall rises only when all four stages
// hold words and out_stall is high, and empty stages close up under stall.
// Write the configuration registers only while the pipeline is empty.

module yuv_matrix_to_argb_pixel_core #(
	parameter int FRACTION_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [yma_pkg::IDX_W-1:0]           cfg_index,
	input  logic [yma_pkg::REG_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [yma_pkg::SAMPLE_W-1:0] sample_y,
	input  logic signed [yma_pkg::SAMPLE_W-1:0] sample_u,
	input  logic signed [yma_pkg::SAMPLE_W-1:0] sample_v,
	input  logic signed [yma_pkg::SAMPLE_W-1:0] alpha_in,
	input  logic                                last_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [yma_pkg::BYTE_W-1:0]          alpha_out,
	output logic [yma_pkg::BYTE_W-1:0]          red,
	output logic [yma_pkg::BYTE_W-1:0]          green,
	output logic [yma_pkg::BYTE_W-1:0]          blue,
	output logic                                end_of_row
);

	localparam int CH_W = yma_pkg::SUM_W - FRACTION_BITS + 1;

	logic [yma_pkg::NUM_CH-1:0][yma_pkg::REG_W-1:0] rows_q;
	logic [yma_pkg::REG_W-1:0]                      offsets_q;
	logic                                           alpha_mode_q;

	logic v_s1, v_s2, v_s3, v_s4;
	yma_pkg::adv_t adv;

	yma_pkg::side_t                                  side_in;
	yma_pkg::prod_row_t [yma_pkg::NUM_CH-1:0]        prod_s1;
	yma_pkg::side_t                                  side_s1;
	logic [yma_pkg::NUM_CH-1:0][CH_W-1:0]            chan_s3;
	yma_pkg::pix_side_t                              side_s3;
	logic [yma_pkg::NUM_CH-1:0][yma_pkg::BYTE_W-1:0] chan_s4;
	yma_pkg::pix_side_t                              side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q       <= '0;
			offsets_q    <= '0;
			alpha_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				yma_pkg::REG_ROW0:  rows_q[0]    <= cfg_data;
				yma_pkg::REG_ROW1:  rows_q[1]    <= cfg_data;
				yma_pkg::REG_ROW2:  rows_q[2]    <= cfg_data;
				yma_pkg::REG_OFFS:  offsets_q    <= cfg_data;
				yma_pkg::REG_AMODE: alpha_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// a stage moves when it is empty or the next one moves
	assign adv.s4   = !v_s4 || !out_stall;
	assign adv.s3   = !v_s3 || adv.s4;
	assign adv.s2   = !v_s2 || adv.s3;
	assign adv.s1   = !v_s1 || adv.s2;
	assign in_stall = !adv.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv.s1) v_s1 <= in_valid;
			if (adv.s2) v_s2 <= v_s1;
			if (adv.s3) v_s3 <= v_s2;
			if (adv.s4) v_s4 <= v_s3;
		end
	end

	assign side_in.alpha = alpha_in;
	assign side_in.last  = last_in;

	yma_mul_stage u_mul (
		.clk      (clk),
		.adv      (adv),
		.sample_y (sample_y),
		.sample_u (sample_u),
		.sample_v (sample_v),
		.side_in  (side_in),
		.rows     (rows_q),
		.prod_s1  (prod_s1),
		.side_s1  (side_s1)
	);

	yma_acc_stage #(
		.FRACTION_BITS (FRACTION_BITS),
		.CH_W          (CH_W)
	) u_acc (
		.clk        (clk),
		.adv        (adv),
		.prod_s1    (prod_s1),
		.side_s1    (side_s1),
		.offsets    (offsets_q),
		.alpha_mode (alpha_mode_q),
		.chan_s3    (chan_s3),
		.side_s3    (side_s3)
	);

	yma_clamp_stage #(
		.CH_W (CH_W)
	) u_clamp (
		.clk     (clk),
		.adv     (adv),
		.chan_s3 (chan_s3),
		.side_s3 (side_s3),
		.chan_s4 (chan_s4),
		.side_s4 (side_s4)
	);

	assign out_valid  = v_s4;
	assign alpha_out  = side_s4.alpha;
	assign red        = chan_s4[0];
	assign green      = chan_s4[1];
	assign blue       = chan_s4[2];
	assign end_of_row = side_s4.last;

	// input backs up only when every stage holds a word
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4))
		else $error("input stalled with an empty stage");

	a_chan_le_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (red <= alpha_out && green <= alpha_out && blue <= alpha_out))
		else $error("color channel above alpha");

	a_opaque_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !alpha_mode_q) |-> (alpha_out == yma_pkg::ALPHA_MAX))
		else $error("opaque word without full alpha");

endmodule
